// ===== hw/rtl/sfcp_pkg.sv =====
// Shared types and codes for the sync frame checksum parser.
`default_nettype none

package sfcp_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned PHASE_W = 3;
   localparam int unsigned TYPE_W  = 2;
   localparam int unsigned ERR_W   = 2;

   // frame phase codes
   localparam logic [PHASE_W-1:0] PH_HUNT    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_SYNC1   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_SYNC2   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_TYPE    = 3'd3;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;
   localparam logic [PHASE_W-1:0] PH_SUMA    = 3'd5;
   localparam logic [PHASE_W-1:0] PH_SUMB    = 3'd6;

   localparam logic [BYTE_W-1:0] MAX_TYPE = 8'd2;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_SYNC2 = 2'd1;
   localparam logic [ERR_W-1:0] ERR_TYPE  = 2'd2;
   localparam logic [ERR_W-1:0] ERR_SUM   = 2'd3;

   // register indexes
   localparam logic CSR_SYNC_FIRST  = 1'b0;
   localparam logic CSR_SYNC_SECOND = 1'b1;

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'd147;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'd224;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [BYTE_W-1:0]  sum_a;
      logic [BYTE_W-1:0]  sum_b;
      logic [TYPE_W-1:0]  held_type;
      logic [BYTE_W-1:0]  held_length;
      logic [BYTE_W-1:0]  byte_count;
   } frame_state_type;

   typedef struct packed {
      logic               payload_valid;
      logic [BYTE_W-1:0]  payload_index;
      logic [BYTE_W-1:0]  payload_byte;
      logic [TYPE_W-1:0]  frame_type;
      logic [BYTE_W-1:0]  frame_length;
      logic               frame_accepted;
      logic [ERR_W-1:0]   error_kind;
   } result_type;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_first;
      logic [BYTE_W-1:0] sync_second;
   } sync_cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sync_frame_checksum_parser_unit.sv =====
// Top level of the sync frame checksum parser: state, config and output skid.
//
//   channel   dir  handshake            payload
//   req_      in   req_valid/req_stall  req_rx_byte
//   rsp_      out  rsp_valid/rsp_stall  payload, frame and error fields
//   csr_      in   csr_write_enable     csr_index, csr_write_data
//
// One byte per cycle while req_stall is low: the frame state step is one
// combinational pass from the state registers into the result register.
// An accepted result is registered in the output register or, behind an older result, in the skid entry.
// An output register plus one skid entry; req_stall rises only when both are full.
// Synchronous reset returns to hunting with sums, held fields and count at zero.
`default_nettype none

module sync_frame_checksum_parser_unit
   import sfcp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_payload_valid,
   output logic [BYTE_W-1:0] rsp_payload_index,
   output logic [BYTE_W-1:0] rsp_payload_byte,
   output logic [TYPE_W-1:0] rsp_frame_type,
   output logic [BYTE_W-1:0] rsp_frame_length,
   output logic              rsp_frame_accepted,
   output logic [ERR_W-1:0]  rsp_error_kind,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [BYTE_W-1:0] csr_write_data
);

   frame_state_type state_ff;
   frame_state_type state_in;
   sync_cfg_type    cfg_ff;
   result_type      step_result;
   result_type      out_ff;
   result_type      skid_ff;
   logic            out_valid_ff;
   logic            skid_valid_ff;
   logic            accept;
   logic            out_free;

   sfcp_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .rx_byte    (req_rx_byte),
      .state_next (state_in),
      .result     (step_result)
   );

   assign accept   = req_valid && !skid_valid_ff;
   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= PH_HUNT;
         state_ff.sum_a       <= '0;
         state_ff.sum_b       <= '0;
         state_ff.held_type   <= '0;
         state_ff.held_length <= '0;
         state_ff.byte_count  <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= SYNC_FIRST_RESET;
         cfg_ff.sync_second <= SYNC_SECOND_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SYNC_FIRST:  cfg_ff.sync_first  <= csr_write_data;
            CSR_SYNC_SECOND: cfg_ff.sync_second <= csr_write_data;
            default: ;
         endcase
      end
   end

   // output register and skid valids
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= accept;
         end else begin
            out_valid_ff  <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff  <= skid_ff;
            skid_ff <= step_result;
         end else begin
            out_ff  <= step_result;
         end
      end else if (accept) begin
         skid_ff <= step_result;
      end
   end

   assign req_stall          = skid_valid_ff;
   assign rsp_valid          = out_valid_ff;
   assign rsp_payload_valid  = out_ff.payload_valid;
   assign rsp_payload_index  = out_ff.payload_index;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_frame_type     = out_ff.frame_type;
   assign rsp_frame_length   = out_ff.frame_length;
   assign rsp_frame_accepted = out_ff.frame_accepted;
   assign rsp_error_kind     = out_ff.error_kind;

endmodule

`default_nettype wire

// ===== hw/rtl/sfcp_step.sv =====
// Per-byte frame state update and result formation.
`default_nettype none

module sfcp_step
   import sfcp_pkg::*;
(
   input  frame_state_type   state,
   input  sync_cfg_type      cfg,
   input  logic [BYTE_W-1:0] rx_byte,
   output frame_state_type   state_next,
   output result_type        result
);

   logic [BYTE_W-1:0] sum_a_add;
   logic [BYTE_W-1:0] sum_b_add;
   logic [BYTE_W-1:0] count_inc;
   logic              payload_valid;
   logic [BYTE_W-1:0] payload_index;
   logic [BYTE_W-1:0] payload_byte;
   logic              accepted;
   logic [ERR_W-1:0]  err;

   assign sum_a_add = state.sum_a + rx_byte;
   assign sum_b_add = state.sum_b + sum_a_add;
   assign count_inc = state.byte_count + 8'd1;

   always_comb begin
      state_next    = state;
      payload_valid = 1'b0;
      payload_index = '0;
      payload_byte  = '0;
      accepted      = 1'b0;
      err           = ERR_NONE;
      case (state.phase)
         PH_HUNT: begin
            if (rx_byte == cfg.sync_first) state_next.phase = PH_SYNC1;
         end
         PH_SYNC1: begin
            if (rx_byte == cfg.sync_second) begin
               state_next.sum_a = '0;
               state_next.sum_b = '0;
               state_next.phase = PH_SYNC2;
            end else begin
               // not re-tried as a first sync
               err              = ERR_SYNC2;
               state_next.phase = PH_HUNT;
            end
         end
         PH_SYNC2: begin
            state_next.sum_a = sum_a_add;
            state_next.sum_b = sum_b_add;
            if (rx_byte > MAX_TYPE) begin
               err              = ERR_TYPE;
               state_next.phase = PH_HUNT;
            end else begin
               state_next.held_type = rx_byte[TYPE_W-1:0];
               state_next.phase     = PH_TYPE;
            end
         end
         PH_TYPE: begin
            state_next.sum_a       = sum_a_add;
            state_next.sum_b       = sum_b_add;
            state_next.held_length = rx_byte;
            state_next.byte_count  = '0;
            state_next.phase       = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            state_next.sum_a      = sum_a_add;
            state_next.sum_b      = sum_b_add;
            payload_valid         = 1'b1;
            payload_index         = state.byte_count;
            payload_byte          = rx_byte;
            state_next.byte_count = count_inc;
            // zero length still takes one byte
            if (count_inc >= state.held_length) state_next.phase = PH_SUMA;
         end
         PH_SUMA: begin
            if (rx_byte == state.sum_a) begin
               state_next.phase = PH_SUMB;
            end else begin
               err              = ERR_SUM;
               state_next.phase = PH_HUNT;
            end
         end
         PH_SUMB: begin
            if (rx_byte == state.sum_b) accepted = 1'b1;
            else err = ERR_SUM;
            state_next.phase = PH_HUNT;
         end
         default: begin
            state_next.phase = PH_HUNT;
         end
      endcase
   end

   assign result.payload_valid  = payload_valid;
   assign result.payload_index  = payload_index;
   assign result.payload_byte   = payload_byte;
   assign result.frame_type     = state_next.held_type;
   assign result.frame_length   = state_next.held_length;
   assign result.frame_accepted = accepted;
   assign result.error_kind     = err;

endmodule

`default_nettype wire

// ===== hw/rtl/sfcp_checker.sv =====
// Port-level checks for the sync frame checksum parser, bound to the top level.
`default_nettype none

module sfcp_checker
   import sfcp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_stall,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_payload_valid,
   input  logic [BYTE_W-1:0] rsp_payload_index,
   input  logic [BYTE_W-1:0] rsp_payload_byte,
   input  logic              rsp_frame_accepted,
   input  logic [ERR_W-1:0]  rsp_error_kind
);

   // a payload byte is never also a frame end or an error
   a_payload_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_valid |-> !rsp_frame_accepted && rsp_error_kind == ERR_NONE)
      else $error("payload transaction flagged as frame end or error");

   a_accept_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_accepted |-> rsp_error_kind == ERR_NONE)
      else $error("accepted frame carries an error code");

   a_idle_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_valid |-> rsp_payload_index == '0 && rsp_payload_byte == '0)
      else $error("payload fields not zero outside payload");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_byte)
                                 && $stable(rsp_error_kind) && $stable(rsp_frame_accepted))
      else $error("stalled result transaction changed");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("handshake not cleared by reset");

endmodule

bind sync_frame_checksum_parser_unit sfcp_checker u_sfcp_checker (.*);

`default_nettype wire
